FILE: sv/base32_stream_encoder_macros.svh
// assertion macros for the base32 stream encoder
`ifndef BASE32_STREAM_ENCODER_MACROS_SVH
`define BASE32_STREAM_ENCODER_MACROS_SVH

`ifndef SYNTHESIS
`define B32E_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("b32e assertion failed");
`define B32E_ASSERT_ALWAYS(lbl, expr) \
  `B32E_ASSERT(lbl, 1'b1 |-> (expr))
`else
`define B32E_ASSERT(lbl, prop)
`define B32E_ASSERT_ALWAYS(lbl, expr)
`endif

`endif

FILE: sv/b32e_pkg.sv
// shared types, constants and helpers for the base32 stream encoder
`default_nettype none

package b32e_pkg;

  localparam int GroupBytes = 5;
  localparam int WordBits   = 8 * GroupBytes;
  localparam int SliceBits  = 5;
  localparam int QDepth     = 2;
  localparam int QAw        = $clog2(QDepth);

  localparam logic [2:0] MaxHeld  = 3'd4;
  localparam logic [3:0] GroupChars = 4'd8;
  localparam logic [6:0] PadCode  = 7'h3D;
  localparam logic [6:0] CodeA    = 7'h41;
  localparam logic [6:0] Code2    = 7'h32;
  localparam logic [4:0] Letters  = 5'd26;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       run_end;
    logic       message_end;
  } out_beat_t;

  typedef struct packed {
    logic [WordBits-1:0] word;
    logic [3:0]          nchars;
    logic [3:0]          total;
    logic                last;
  } grp_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

  function automatic logic [6:0] b32_char(input logic [4:0] slice);
    logic [4:0] off;
    begin
      off = slice - Letters;
      if (slice < Letters) begin
        b32_char = CodeA + {2'b00, slice};
      end else begin
        b32_char = Code2 + {2'b00, off};
      end
    end
  endfunction

  function automatic logic [3:0] data_chars(input logic [2:0] held);
    begin
      unique case (held)
        3'd0:    data_chars = 4'd2;
        3'd1:    data_chars = 4'd4;
        3'd2:    data_chars = 4'd5;
        3'd3:    data_chars = 4'd7;
        default: data_chars = 4'd8;
      endcase
    end
  endfunction

endpackage

`default_nettype wire

FILE: sv/b32e_front.sv
// front part: gathers bytes into groups and builds group descriptors
`default_nettype none

module b32e_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  b32e_pkg::in_beat_t in_data,
  input  logic               no_pad,
  input  logic               q_full,
  output logic               accept,
  output logic               q_push,
  output b32e_pkg::grp_t     q_data
);
  import b32e_pkg::*;

  logic [31:0] held_r;
  logic [31:0] held_nxt;
  logic [2:0]  cnt_r;
  logic [2:0]  cnt_nxt;
  logic        done;
  logic [3:0]  nch;

  assign accept = in_push && !q_full;
  assign done   = in_data.last_byte || (cnt_r >= MaxHeld);
  assign q_push = accept && done;
  assign nch    = data_chars(cnt_r);

  always_comb begin
    q_data.nchars = nch;
    q_data.total  = no_pad ? nch : GroupChars;
    q_data.last   = in_data.last_byte;
    unique case (cnt_r)
      3'd0:    q_data.word = {in_data.data_byte, 32'd0};
      3'd1:    q_data.word = {held_r[7:0], in_data.data_byte, 24'd0};
      3'd2:    q_data.word = {held_r[15:0], in_data.data_byte, 16'd0};
      3'd3:    q_data.word = {held_r[23:0], in_data.data_byte, 8'd0};
      default: q_data.word = {held_r, in_data.data_byte};
    endcase
  end

  always_comb begin
    held_nxt = held_r;
    cnt_nxt  = cnt_r;
    if (accept) begin
      if (done) begin
        held_nxt = '0;
        cnt_nxt  = '0;
      end else begin
        held_nxt = {held_r[23:0], in_data.data_byte};
        cnt_nxt  = cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      cnt_r  <= '0;
    end else begin
      held_r <= held_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/b32e_fifo.sv
// short queue of group descriptors between front and back
`default_nettype none

`include "base32_stream_encoder_macros.svh"

module b32e_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b32e_pkg::grp_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output b32e_pkg::grp_t rdata
);
  import b32e_pkg::*;

  grp_t           mem_r [QDepth];
  logic [QAw-1:0] wp_r;
  logic [QAw-1:0] wp_nxt;
  logic [QAw-1:0] rp_r;
  logic [QAw-1:0] rp_nxt;
  logic [QAw:0]   cnt_r;
  logic [QAw:0]   cnt_nxt;
  logic           do_push;
  logic           do_pop;

  localparam logic [QAw:0] Depth = (QAw+1)'(QDepth);

  assign full    = (cnt_r == Depth);
  assign valid   = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + QAw'(1) : wp_r;
    rp_nxt  = do_pop ? rp_r + QAw'(1) : rp_r;
    cnt_nxt = cnt_r + (QAw+1)'(do_push) - (QAw+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `B32E_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= Depth)
  `B32E_ASSERT_ALWAYS(a_no_pop_empty, !(pop && !valid))
  `B32E_ASSERT(a_push_counts, (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + (QAw+1)'(1)))

endmodule

`default_nettype wire

FILE: sv/b32e_back.sv
// back part: turns group descriptors into characters, one per cycle while the output is free
`default_nettype none

`include "base32_stream_encoder_macros.svh"

module b32e_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  b32e_pkg::grp_t      q_data,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output b32e_pkg::out_beat_t out_data
);
  import b32e_pkg::*;

  grp_t                cur_r;
  logic [WordBits-1:0] sh_r;
  logic [2:0]          idx_r;
  logic                busy_r;
  logic                oval_r;
  out_beat_t           out_r;
  logic                adv;
  logic                is_last;
  logic                is_data;
  out_beat_t           beat;

  assign adv     = busy_r && (!oval_r || out_pop);
  assign is_last = ({1'b0, idx_r} == (cur_r.total - 4'd1));
  assign is_data = ({1'b0, idx_r} < cur_r.nchars);
  assign q_pop   = q_valid && (!busy_r || (adv && is_last));

  always_comb begin
    beat.char_code   = is_data ? b32_char(sh_r[WordBits-1 -: SliceBits]) : PadCode;
    beat.run_end     = is_last;
    beat.message_end = is_last && cur_r.last;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
      sh_r  <= q_data.word;
    end else if (adv) begin
      sh_r  <= {sh_r[WordBits-SliceBits-1:0], {SliceBits{1'b0}}};
    end
    if (adv) begin
      out_r <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      busy_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      if (q_pop) begin
        idx_r  <= '0;
        busy_r <= 1'b1;
      end else if (adv) begin
        idx_r  <= idx_r + 3'd1;
        busy_r <= !is_last;
      end
      if (adv) begin
        oval_r <= 1'b1;
      end else if (out_pop) begin
        oval_r <= 1'b0;
      end
    end
  end

  assign out_empty = !oval_r;
  assign out_data  = out_r;

  `B32E_ASSERT_ALWAYS(a_msg_has_run, !(oval_r && out_r.message_end && !out_r.run_end))
  `B32E_ASSERT_ALWAYS(a_idx_in_range, !busy_r || ({1'b0, idx_r} < cur_r.total))
  `B32E_ASSERT(a_group_closes, (adv && is_last && !q_valid) |=> !busy_r)

endmodule

`default_nettype wire

FILE: sv/base32_stream_encoder.sv
// top level of the base32 stream encoder
//
//   channel | ports                         | beat
//   input   | in_push, in_full, in_data     | one message byte and its last flag
//   result  | out_empty, out_pop, out_data  | one character with run and message ends
//   config  | cfg_valid, cfg_ready, cfg_no_pad | no_pad register
//
// a byte is taken every cycle while the group queue has room; a completed
// group leaves the front in the cycle its closing byte is accepted
// the back emits one character per cycle while the output register is empty or
// popped; a group gives 8 characters (2, 4, 5 or 7 for a short unpadded group),
// so the rate is set by the single character port
// the output register lets a new character load in the cycle the old one pops
// synchronous active-low reset clears the group count, queue and output valid
`default_nettype none

module base32_stream_encoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  b32e_pkg::in_beat_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output b32e_pkg::out_beat_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_no_pad
);
  import b32e_pkg::*;

  logic  no_pad_r;
  logic  accept;
  q_wr_t qw;
  grp_t  wgrp;
  logic  q_valid;
  logic  q_pop;
  grp_t  rgrp;

  assign cfg_ready = 1'b1;
  assign in_full   = !accept && in_push ? 1'b1 : qw.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      no_pad_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      no_pad_r <= cfg_no_pad;
    end
  end

  b32e_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .no_pad  (no_pad_r),
    .q_full  (qw.full),
    .accept  (accept),
    .q_push  (qw.push),
    .q_data  (wgrp)
  );

  b32e_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (qw.push),
    .wdata (wgrp),
    .full  (qw.full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (rgrp)
  );

  b32e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (rgrp),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb_base32_stream_encoder.sv
// self-checking testbench for the base32 stream encoder
module tb_base32_stream_encoder;

  localparam logic [6:0] CHAR_A   = 7'h41;
  localparam logic [6:0] CHAR_TWO = 7'h32;
  localparam logic [6:0] CHAR_PAD = 7'h3D;
  localparam int         NUM_ROWS = 25;
  localparam int         SETTLE   = 8;

  typedef struct {
    logic       wr;
    logic       pad;
    logic [7:0] data;
    logic       last;
    string      want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  logic                in_full;
  b32e_pkg::in_beat_t  in_data = '0;
  logic                out_empty;
  logic                out_pop = 1'b0;
  b32e_pkg::out_beat_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_no_pad = 1'b0;

  // encoder state as predicted
  logic [31:0] held_word = '0;
  logic [2:0]  held_cnt = '0;
  logic        pad_off = 1'b0;

  b32e_pkg::out_beat_t group_chars[8];
  b32e_pkg::out_beat_t char_q[$];

  int errors = 0;
  int bytes_sent = 0;
  int msgs_sent = 0;
  int chars_seen = 0;
  int cfg_writes = 0;
  int send_idle = 25;
  int recv_idle = 71;
  int stall_left = 0;

  // "f" "o" "o" "b" "a" are 66 6f 6f 62 61
  dir_row_t dir_rows[NUM_ROWS] = '{
    '{1'b1, 1'b0, 8'h66, 1'b1, "MY======"},
    '{1'b0, 1'b0, 8'h66, 1'b0, ""},
    '{1'b0, 1'b0, 8'h6F, 1'b1, "MZXQ===="},
    '{1'b0, 1'b0, 8'h66, 1'b0, ""},
    '{1'b0, 1'b0, 8'h6F, 1'b0, ""},
    '{1'b0, 1'b0, 8'h6F, 1'b1, "MZXW6==="},
    '{1'b0, 1'b0, 8'h66, 1'b0, ""},
    '{1'b0, 1'b0, 8'h6F, 1'b0, ""},
    '{1'b0, 1'b0, 8'h6F, 1'b0, ""},
    '{1'b0, 1'b0, 8'h62, 1'b1, "MZXW6YQ="},
    '{1'b0, 1'b0, 8'h66, 1'b0, ""},
    '{1'b0, 1'b0, 8'h6F, 1'b0, ""},
    '{1'b0, 1'b0, 8'h6F, 1'b0, ""},
    '{1'b0, 1'b0, 8'h62, 1'b0, ""},
    '{1'b0, 1'b0, 8'h61, 1'b1, "MZXW6YTB"},
    '{1'b0, 1'b0, 8'hFF, 1'b0, ""},
    '{1'b0, 1'b0, 8'hFF, 1'b0, ""},
    '{1'b0, 1'b0, 8'hFF, 1'b0, ""},
    '{1'b0, 1'b0, 8'hFF, 1'b0, ""},
    '{1'b0, 1'b0, 8'hFF, 1'b0, "77777777"},
    '{1'b0, 1'b0, 8'h00, 1'b1, "AA======"},
    '{1'b1, 1'b1, 8'hFF, 1'b1, "74"},
    '{1'b0, 1'b1, 8'h66, 1'b0, ""},
    '{1'b0, 1'b1, 8'h6F, 1'b0, ""},
    '{1'b1, 1'b0, 8'h6F, 1'b1, "MZXW6==="}
  };

  base32_stream_encoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_data    (in_data),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_no_pad (cfg_no_pad)
  );

  initial begin
    forever begin
      #2 clk = ~clk;
    end
  end

  initial begin
    #2000000;
    $display("tb_base32_stream_encoder: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 50) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  // takes one byte, returns the number of characters its group emits
  function automatic int encode_byte(input b32e_pkg::in_beat_t beat);
    logic [39:0] word;
    logic [4:0]  slice;
    logic [6:0]  code;
    int          n;
    int          nchars;
    int          total;
    if (held_cnt < 3'd4 && !beat.last_byte) begin
      held_word = {held_word[23:0], beat.data_byte};
      held_cnt = held_cnt + 3'd1;
      return 0;
    end
    n = int'(held_cnt) + 1;
    word = {held_word, beat.data_byte};
    word = word << (8 * (5 - n));
    case (n)
      1:       nchars = 2;
      2:       nchars = 4;
      3:       nchars = 5;
      4:       nchars = 7;
      default: nchars = 8;
    endcase
    total = pad_off ? nchars : 8;
    for (int k = 0; k < total; k++) begin
      if (k < nchars) begin
        slice = 5'(word >> (35 - 5 * k));
        code = (slice < 5'd26) ? CHAR_A + 7'(slice) : CHAR_TWO + 7'(slice - 5'd26);
      end else begin
        code = CHAR_PAD;
      end
      group_chars[k].char_code = code;
      group_chars[k].run_end = (k == total - 1);
      group_chars[k].message_end = (k == total - 1) && beat.last_byte;
    end
    held_word = '0;
    held_cnt = '0;
    return total;
  endfunction

  task automatic send_byte(input b32e_pkg::in_beat_t beat, input string want);
    b32e_pkg::out_beat_t typed;
    byte                 ch;
    int                  n;
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_full);
    n = encode_byte(beat);
    bytes_sent++;
    if (beat.last_byte) msgs_sent++;
    if (want.len() > 0) begin
      for (int k = 0; k < want.len(); k++) begin
        ch = want[k];
        typed.char_code = ch[6:0];
        typed.run_end = (k == want.len() - 1);
        typed.message_end = (k == want.len() - 1) && beat.last_byte;
        char_q.push_back(typed);
      end
    end else begin
      for (int k = 0; k < n; k++) char_q.push_back(group_chars[k]);
    end
  endtask

  // stop sending and let every expected character come out
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (char_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_no_pad(input logic value);
    cfg_valid <= 1'b1;
    cfg_no_pad <= value;
    do @(posedge clk); while (!cfg_ready);
    pad_off = value;
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_message(input int len, input bit mid_cfg);
    b32e_pkg::in_beat_t beat;
    for (int i = 0; i < len; i++) begin
      if (mid_cfg && i > 0 && $urandom_range(11) == 0) begin
        drain();
        write_no_pad(1'($urandom_range(1)));
      end
      beat.data_byte = 8'($urandom_range(255));
      beat.last_byte = (i == len - 1);
      send_byte(beat, "");
    end
  endtask

  task automatic check_char(input b32e_pkg::out_beat_t got);
    b32e_pkg::out_beat_t want;
    chars_seen++;
    if (char_q.size() == 0) begin
      report_mismatch($sformatf("char 0x%02h with nothing expected", got.char_code));
      return;
    end
    want = char_q.pop_front();
    if (got.char_code != want.char_code) begin
      report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
                                got.char_code, want.char_code));
    end
    if (got.run_end != want.run_end) begin
      report_mismatch($sformatf("run_end %0b, expected %0b", got.run_end, want.run_end));
    end
    if (got.message_end != want.message_end) begin
      report_mismatch($sformatf("message_end %0b, expected %0b",
                                got.message_end, want.message_end));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) check_char(out_data);
    if (stall_left > 0) begin
      stall_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    b32e_pkg::in_beat_t beat;
    int                 first;
    int                 target;
    int                 len;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (dir_rows[i].wr) begin
        drain();
        write_no_pad(dir_rows[i].pad);
      end
      beat.data_byte = dir_rows[i].data;
      beat.last_byte = dir_rows[i].last;
      send_byte(beat, dir_rows[i].want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      drain();
      case (phase)
        0: begin
          send_idle = 25;
          recv_idle = 71;
        end
        1: begin
          send_idle = 71;
          recv_idle = 25;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      write_no_pad(phase[0]);
      first = bytes_sent;
      target = (phase == 2) ? 45 : 40;
      if (phase == 2) begin
        // receiver holds off while bytes keep coming, so the input backs up
        stall_left = 80;
        send_message(30, 1'b0);
      end
      while (bytes_sent - first < target) begin
        if ($urandom_range(3) == 0) begin
          drain();
          write_no_pad(1'($urandom_range(1)));
        end
        len = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 12);
        send_message(len, 1'b1);
      end
    end

    drain();
    $display("sent %0d bytes in %0d messages, checked %0d characters, %0d no_pad writes",
             bytes_sent, msgs_sent, chars_seen, cfg_writes);
    if (errors == 0) begin
      $display("tb_base32_stream_encoder: PASS");
    end else begin
      $display("tb_base32_stream_encoder: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/b32e_pkg.sv
sv/b32e_front.sv
sv/b32e_fifo.sv
sv/b32e_back.sv
sv/base32_stream_encoder.sv
tb/sv/tb_base32_stream_encoder.sv
